// File: design/tetd_pkg.sv
// Shared types and constants for the tape edge timing decoder.
// No dependencies; imported by the configuration, core and top modules.
package tetd_pkg;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;
  localparam int TIMEOUT_W   = 16;
  localparam int SYNC_W      = 5;
  localparam int PERIOD_W    = 16;
  localparam int BYTE_W      = 8;
  localparam int BITS_HELD_W = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_TIMEOUT    = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SYNC_EDGES = 1'b1;

  localparam logic [TIMEOUT_W-1:0]   TIMEOUT_RESET    = 16'd5000;
  localparam logic [SYNC_W-1:0]      SYNC_EDGES_RESET = 5'd16;
  localparam logic [BITS_HELD_W-1:0] BYTE_BITS        = 4'd8;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_cycles;
    logic [SYNC_W-1:0]    sync_edges;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [BYTE_W-1:0] data_byte;
  } result_t;

endpackage

// File: design/tetd_edge_if.sv
// Edge timestamp channel: valid/ready handshake with the edge_time payload.
// Width follows the time counter width of the top level.
interface tetd_edge_if #(
  parameter int TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic [TIME_BITS-1:0] edge_time;

  modport source (output valid, output edge_time, input ready);
  modport sink (input valid, input edge_time, output ready);
endinterface

// File: design/tetd_byte_if.sv
// Decoded byte channel: valid/ready handshake with the data_byte payload.
// No dependencies.
interface tetd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: design/tetd_cfg_regs.sv
// Configuration registers: timeout and sync edge count, written by index.
// Depends on tetd_pkg.
module tetd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [tetd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [tetd_pkg::CFG_DATA_W-1:0]  wr_data,
  output tetd_pkg::cfg_t                   cfg
);
  import tetd_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_cycles <= TIMEOUT_RESET;
      cfg.sync_edges     <= SYNC_EDGES_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_TIMEOUT:    cfg.timeout_cycles <= wr_data[TIMEOUT_W-1:0];
        REG_SYNC_EDGES: cfg.sync_edges     <= wr_data[SYNC_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: design/tetd_core.sv
// Decoder state and per-edge update: interval, sync tracking, bit decoding.
// Depends on tetd_pkg; one edge is consumed per cycle when fire is high.
module tetd_core #(
  parameter int TIME_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 fire,
  input  logic [TIME_BITS-1:0] edge_time,
  input  tetd_pkg::cfg_t       cfg,
  output tetd_pkg::result_t    result
);
  import tetd_pkg::*;

  logic [TIME_BITS-1:0]   last_edge_time, last_edge_time_next;
  logic [SYNC_W-1:0]      sync_left, sync_left_next;
  logic [PERIOD_W-1:0]    tracked_period, tracked_period_next;
  logic                   started, started_next;
  logic                   half_phase, half_phase_next;
  logic                   current_bit, current_bit_next;
  logic [BYTE_W-1:0]      shift_byte, shift_byte_next;
  logic [BITS_HELD_W-1:0] bits_held, bits_held_next;

  logic [TIME_BITS-1:0]   interval;
  logic [PERIOD_W-1:0]    t16;
  logic [PERIOD_W-1:0]    half;
  logic [PERIOD_W:0]      p_plus_half;
  logic [PERIOD_W+1:0]    p_triple;
  logic                   timeout_hit;
  logic                   too_short;
  logic                   too_long_sync;
  logic                   too_long_data;
  logic                   is_long;
  logic [PERIOD_W:0]      sum_short;
  logic [PERIOD_W:0]      sum_long;
  logic                   bit_new;
  logic                   do_shift;
  logic [BYTE_W-1:0]      shifted;
  logic [BITS_HELD_W-1:0] bits_inc;

  assign interval      = edge_time - last_edge_time;
  assign timeout_hit   = interval > TIME_BITS'(cfg.timeout_cycles);
  assign t16           = interval[PERIOD_W-1:0];
  assign half          = tracked_period >> 1;
  assign p_plus_half   = {1'b0, tracked_period} + {1'b0, half};
  assign p_triple      = {1'b0, tracked_period, 1'b0} + {2'b00, tracked_period};
  assign too_short     = t16 < half;
  assign too_long_sync = {1'b0, t16} > p_plus_half;
  assign too_long_data = {2'b00, t16} > p_triple;
  assign is_long       = {1'b0, t16} >= p_plus_half;
  assign sum_short     = {1'b0, tracked_period} + {1'b0, t16};
  assign sum_long      = {1'b0, tracked_period} + {2'b00, t16[PERIOD_W-1:1]};
  assign bit_new       = is_long ? ~current_bit : current_bit;
  assign do_shift      = is_long || !half_phase;
  assign shifted       = {shift_byte[BYTE_W-2:0], bit_new};
  assign bits_inc      = bits_held + BITS_HELD_W'(1);

  always_comb begin
    last_edge_time_next = last_edge_time;
    sync_left_next      = sync_left;
    tracked_period_next = tracked_period;
    started_next        = started;
    half_phase_next     = half_phase;
    current_bit_next    = current_bit;
    shift_byte_next     = shift_byte;
    bits_held_next      = bits_held;
    result.valid        = 1'b0;
    result.data_byte    = shifted;
    if (fire) begin
      last_edge_time_next = edge_time;
      if (timeout_hit) begin
        sync_left_next = cfg.sync_edges;
        started_next   = 1'b0;
      end else if (sync_left != '0) begin
        if (too_short || too_long_sync) begin
          tracked_period_next = t16;
          sync_left_next      = cfg.sync_edges;
          started_next        = 1'b0;
        end else begin
          tracked_period_next = sum_short[PERIOD_W:1];
          sync_left_next      = sync_left - SYNC_W'(1);
        end
      end else if (too_short || too_long_data) begin
        tracked_period_next = t16;
        sync_left_next      = cfg.sync_edges;
        started_next        = 1'b0;
      end else begin
        tracked_period_next = is_long ? sum_long[PERIOD_W:1] : sum_short[PERIOD_W:1];
        if (!started) begin
          // start bit seeds the byte as its top bit
          if (is_long) begin
            current_bit_next = 1'b1;
            started_next     = 1'b1;
            half_phase_next  = 1'b1;
            shift_byte_next  = BYTE_W'(1);
            bits_held_next   = BITS_HELD_W'(1);
          end
        end else begin
          current_bit_next = bit_new;
          half_phase_next  = is_long ? 1'b1 : ~half_phase;
          if (do_shift) begin
            if (bits_inc == BYTE_BITS) begin
              result.valid    = 1'b1;
              shift_byte_next = '0;
              bits_held_next  = '0;
            end else begin
              shift_byte_next = shifted;
              bits_held_next  = bits_inc;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_edge_time <= '0;
      sync_left      <= SYNC_EDGES_RESET;
      tracked_period <= '0;
      started        <= 1'b0;
      half_phase     <= 1'b0;
      current_bit    <= 1'b0;
      shift_byte     <= '0;
      bits_held      <= '0;
    end else begin
      last_edge_time <= last_edge_time_next;
      sync_left      <= sync_left_next;
      tracked_period <= tracked_period_next;
      started        <= started_next;
      half_phase     <= half_phase_next;
      current_bit    <= current_bit_next;
      shift_byte     <= shift_byte_next;
      bits_held      <= bits_held_next;
    end
  end

endmodule

// File: design/tape_edge_timing_decoder.sv
// Tape edge timing decoder, top level: input register, decoder core, output register.
// Path: an edge is held in the input register, decoded by tetd_core on fire, then the byte is registered.
// Throughput: one edge per cycle while the output register is not stalled by bytes.ready.
// Reset: synchronous rst clears all decoder state and restores register defaults
// (timeout 5000, sync edges 16); the block accepts edges in the first cycle after.
// Depends on tetd_pkg, tetd_edge_if, tetd_byte_if, tetd_cfg_regs, tetd_core.
module tape_edge_timing_decoder #(
  parameter int TIME_BITS = 32
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [tetd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [tetd_pkg::CFG_DATA_W-1:0]  wr_data,
  tetd_edge_if.sink                        edges,
  tetd_byte_if.source                      bytes
);
  import tetd_pkg::*;

  cfg_t                 cfg;
  result_t              result;
  logic                 in_valid;
  logic [TIME_BITS-1:0] edge_q;
  logic                 out_valid;
  logic [BYTE_W-1:0]    out_byte;
  logic                 fire;

  assign fire        = in_valid && (!out_valid || bytes.ready);
  assign edges.ready = !in_valid || fire;

  tetd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  tetd_core #(
    .TIME_BITS (TIME_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .edge_time (edge_q),
    .cfg       (cfg),
    .result    (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (edges.valid && edges.ready) begin
        in_valid <= 1'b1;
        edge_q   <= edges.edge_time;
      end else if (fire) begin
        in_valid <= 1'b0;
      end
      // hold the byte until the transaction completes
      if (fire && result.valid) begin
        out_valid <= 1'b1;
        out_byte  <= result.data_byte;
      end else if (bytes.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign bytes.valid     = out_valid;
  assign bytes.data_byte = out_byte;

`ifndef SYNTH
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !fire |=> in_valid && $stable(edge_q))
    else $error("input register changed while stalled");

  a_out_from_fire: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(fire))
    else $error("byte appeared without a processed edge");

  a_no_fire_idle: assert property (@(posedge clk) disable iff (rst)
    !in_valid |-> !fire)
    else $error("core advanced with an empty input register");
`endif

endmodule
